// ===== rtl/atm_pkg.sv =====
`default_nettype none

package atm_pkg;

    localparam int WORD_BITS_DEF  = 64;
    localparam int MAX_BLOCKS_DEF = 16;
    localparam int ALPHABET_DEF   = 128;

    // field widths of one input item and of one result
    localparam int CMD_W    = 2;
    localparam int SYM_W    = 7;
    localparam int BLK_W    = 4;
    localparam int TWORD_W  = 64;
    localparam int POS_W    = 32;
    localparam int IN_W     = CMD_W + SYM_W + BLK_W + TWORD_W;
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;

    // configuration registers
    localparam int KERR_W   = 6;
    localparam int PLEN_W   = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = PLEN_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_TEXT    = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_ERRORS     = 1'b0,
        REG_PATTERN_LENGTH = 1'b1
    } cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/approximate_text_matcher.sv =====
`default_nettype none

// Approximate text matcher: reports each text position where the pattern ends
// with at most max_errors edit errors (capped at WORD_BITS - 2), using packed automaton diagonals.
// Channels: s_axis carries items (load table word, text symbol, restart);
// m_axis carries one 32-bit end position for each text symbol that matches;
// cfg writes max_errors (index 0) and pattern_length (index 1).
// Sequencing: a load or restart is handled in the idle state. A text symbol
// goes through the filter state while only the filter word is active, and
// otherwise through a sequential sweep over the diagonal-word memory (one
// block a cycle through one read and one write port, registered read) and
// a post state; if the top block fails its test, a shrink state checks for
// a drop, rereading the block below after a drop that leaves blocks active.
// Reset and every configuration write run a derivation of the word masks
// (two 11-step serial divisions and one step per diagonal of a word),
// during which s_axis_tready and cfg_ready stay low; it ends by restarting
// the search state. The pattern table is not cleared.
// A result waits in an output register while the next transaction is taken;
// a symbol that matches while that register is still full holds until the
// receiver takes the pending result.
module approximate_text_matcher
    import atm_pkg::*;
#(
    parameter int WORD_BITS  = WORD_BITS_DEF,
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int ALPHABET   = ALPHABET_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // command[1:0], symbol[8:2], block_index[12:9], table_word[76:13], zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // end_position[31:0]
    output logic [POS_W-1:0]            m_axis_tdata,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int W   = WORD_BITS;
    localparam int SW  = $clog2(W + 1);
    localparam int AW  = $clog2(MAX_BLOCKS + 1);
    localparam int CW  = $clog2(MAX_BLOCKS + 2);
    localparam int TD  = ALPHABET * MAX_BLOCKS;
    localparam int TAW = $clog2(TD);
    localparam int DVW = PLEN_W;
    localparam int DCW = $clog2(DVW);
    localparam logic [W-1:0] ONE_W = W'(1);

    typedef enum logic [3:0] {
        ST_INIT, ST_DIVA, ST_DIVB, ST_MASK, ST_FIN,
        ST_IDLE, ST_FILT, ST_RUN, ST_POST, ST_SHRINK, ST_SHRD
    } state_t;

    state_t state_reg;

    // configuration and derived values
    logic [KERR_W-1:0] max_errors_reg;
    logic [PLEN_W-1:0] pattern_length_reg;
    logic [SW-1:0]     errs_reg, stride_reg, pw_reg, shiftj_reg, ld_reg, mi_reg;
    logic [AW-1:0]     last_blk_reg;
    logic [W-1:0]      din_reg, m1_reg, m2_reg, gl_reg, gi_reg;

    // serial divider
    logic [DVW-1:0]    div_dvd_reg, div_dsr_reg, div_rem_reg, div_q_reg;
    logic [DCW-1:0]    div_cnt_reg;

    // search state
    logic [W-1:0]      fw_reg, top_reg, below_reg, old_reg, cprev_reg, prev_new_reg;
    logic [AW-1:0]     a_reg;
    logic [CW-1:0]     cnt_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [SYM_W-1:0]  sym_reg;
    logic              sym_oor_reg;
    logic              out_valid_reg;
    logic [POS_W-1:0]  out_data_reg;
    logic [MAX_BLOCKS:0] diag_valid_reg;

    // memories
    logic [W-1:0]      diag_mem [0:MAX_BLOCKS];
    logic [W-1:0]      tbl_mem  [0:TD-1];
    logic [W-1:0]      diag_rdata_reg, tbl_rdata_reg;
    logic              diag_rvalid_reg;

    // input fields
    logic [CMD_W-1:0]   in_cmd;
    logic [SYM_W-1:0]   in_sym;
    logic [BLK_W-1:0]   in_blk;
    logic [TWORD_W-1:0] in_word;

    assign in_cmd  = s_axis_tdata[CMD_W-1:0];
    assign in_sym  = s_axis_tdata[CMD_W +: SYM_W];
    assign in_blk  = s_axis_tdata[CMD_W+SYM_W +: BLK_W];
    assign in_word = s_axis_tdata[CMD_W+SYM_W+BLK_W +: TWORD_W];

    logic in_acc, cfg_acc, out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = (state_reg == ST_IDLE) && !s_axis_tvalid;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_acc       = cfg_valid && cfg_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // ---------------- derivation helpers ----------------
    logic [7:0]      me8;
    logic [SW-1:0]   errs_c;
    logic [W-1:0]    m3;
    logic [DVW-1:0]  span;
    logic [DVW-1:0]  div_trial, div_rem_new, div_q_new;
    logic            div_ge;
    logic [SW-1:0]   rp1, spanmod;
    logic [2*SW-1:0] gl_amt, ld_full;

    always_comb
    begin
        me8    = 8'(max_errors_reg);
        errs_c = (me8 > 8'(W - 2)) ? SW'(W - 2) : SW'(max_errors_reg);
        m3     = {W{1'b1}} >> (SW'(W - 1) - errs_reg);
        span   = (pattern_length_reg > DVW'(errs_reg))
               ? pattern_length_reg - DVW'(errs_reg) : DVW'(1);
        div_trial   = {div_rem_reg[DVW-2:0], div_dvd_reg[DVW-1]};
        div_ge      = (div_trial >= div_dsr_reg);
        div_rem_new = div_ge ? div_trial - div_dsr_reg : div_trial;
        div_q_new   = {div_q_reg[DVW-2:0], div_ge};
        rp1     = SW'(div_rem_new) + SW'(1);
        spanmod = (rp1 == pw_reg) ? SW'(0) : rp1;
        gl_amt  = (2*SW)'(stride_reg) * (2*SW)'(shiftj_reg) + (2*SW)'(errs_reg);
        ld_full = (2*SW)'(stride_reg) * (2*SW)'(pw_reg - SW'(1));
    end

    // ---------------- word recurrences ----------------
    logic          pw1;
    logic [W-1:0]  t_eff, diag_eff;
    logic [W-1:0]  fx, fxs, fc;
    logic [W-1:0]  rx, rxs, rnew;
    logic [AW-1:0] j_idx;

    always_comb
    begin
        pw1      = (pw_reg == SW'(1));
        t_eff    = sym_oor_reg ? din_reg : tbl_rdata_reg;
        diag_eff = diag_rvalid_reg ? diag_rdata_reg : din_reg;
        // filter word
        fx  = pw1 ? t_eff : ((fw_reg >> stride_reg) | t_eff);
        fxs = ((fx + m1_reg) ^ fx) >> 1;
        if (pw1)
            fc = ((fw_reg << 1) | ONE_W) & fxs & din_reg;
        else
            fc = ((fw_reg << 1) | m1_reg) & ((fw_reg << (stride_reg + SW'(1))) | m2_reg)
               & fxs & din_reg;
        // one diagonal block: old_reg is d[j], diag_eff is d[j+1]
        rx  = pw1 ? (cprev_reg | t_eff)
                  : ((old_reg >> stride_reg) | (cprev_reg << ld_reg) | t_eff);
        rxs = ((rx + m1_reg) ^ rx) >> 1;
        if (pw1)
            rnew = (((old_reg & diag_eff) << 1) | ONE_W) & rxs & din_reg;
        else
            rnew = (((old_reg << 1) & ((old_reg << (stride_reg + SW'(1)))
                   | (diag_eff >> (ld_reg - SW'(1))))) | m1_reg) & rxs & din_reg;
        j_idx = AW'(cnt_reg - CW'(2));
    end

    // ---------------- memory addressing ----------------
    logic [AW-1:0]  diag_raddr, diag_waddr;
    logic [W-1:0]   diag_wdata;
    logic           diag_we;
    logic [TAW-1:0] taddr_in, taddr_run, tbl_raddr;
    logic           tbl_we, tbl_re, in_sym_ok, in_blk_ok;

    always_comb
    begin
        if (state_reg == ST_SHRINK)
            diag_raddr = a_reg - AW'(2);
        else if (cnt_reg > CW'(MAX_BLOCKS))
            diag_raddr = AW'(MAX_BLOCKS);
        else
            diag_raddr = AW'(cnt_reg);

        diag_we    = 1'b0;
        diag_waddr = j_idx;
        diag_wdata = rnew;
        if (state_reg == ST_FILT && last_blk_reg != AW'(0) && (fc & gi_reg) == '0)
        begin
            diag_we    = 1'b1;
            diag_waddr = AW'(0);
            diag_wdata = fc;
        end
        else if (state_reg == ST_RUN && cnt_reg >= CW'(2))
        begin
            diag_we = 1'b1;
        end

        in_sym_ok = ({1'b0, in_sym} < 8'(ALPHABET));
        in_blk_ok = (7'(in_blk) < 7'(MAX_BLOCKS));
        taddr_in  = TAW'(in_sym) * TAW'(MAX_BLOCKS) + TAW'(in_blk);
        taddr_run = TAW'(sym_reg) * TAW'(MAX_BLOCKS) + TAW'(cnt_reg - CW'(1));
        tbl_we    = in_acc && (in_cmd == CMD_LOAD) && in_sym_ok && in_blk_ok;
        if (state_reg == ST_RUN)
        begin
            tbl_raddr = taddr_run;
            tbl_re    = (cnt_reg >= CW'(1)) && (cnt_reg <= CW'(a_reg) + CW'(1));
        end
        else
        begin
            tbl_raddr = TAW'(in_sym) * TAW'(MAX_BLOCKS);
            tbl_re    = in_acc && (in_cmd == CMD_TEXT) && in_sym_ok;
        end
    end

    // diagonal-word memory: one write, one read port, registered read
    always_ff @(posedge clk)
    begin
        if (diag_we)
            diag_mem[diag_waddr] <= diag_wdata;
        diag_rdata_reg  <= diag_mem[diag_raddr];
        diag_rvalid_reg <= diag_valid_reg[diag_raddr];
    end

    // pattern table memory
    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_mem[taddr_in] <= in_word[W-1:0];
        if (tbl_re)
            tbl_rdata_reg <= tbl_mem[tbl_raddr];
    end

    // ---------------- control ----------------
    logic [W-1:0]  g_sel;
    logic          shrink_ok;
    logic [AW-1:0] a_dec;
    logic          res_set;

    always_comb
    begin
        g_sel     = (a_reg == last_blk_reg) ? gl_reg : gi_reg;
        shrink_ok = ((~top_reg & din_reg) == '0) && ((below_reg & gi_reg) != '0);
        a_dec     = a_reg - AW'(1);
        // a new result is loaded into the output register this cycle
        res_set   = out_free
                  && (((state_reg == ST_FILT) && (last_blk_reg == AW'(0))
                       && ((fc & gl_reg) == '0))
                   || ((state_reg == ST_POST) && ((top_reg & g_sel) == '0)
                       && (a_reg == last_blk_reg)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_INIT;
            max_errors_reg     <= '0;
            pattern_length_reg <= PLEN_W'(1);
            a_reg              <= '0;
            pos_reg            <= '0;
            out_valid_reg      <= 1'b0;
            diag_valid_reg     <= '0;
            cnt_reg            <= '0;
            div_cnt_reg        <= '0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready && !res_set)
                out_valid_reg <= 1'b0;
            if (diag_we)
                diag_valid_reg[diag_waddr] <= 1'b1;

            case (state_reg)
                ST_INIT:
                begin
                    errs_reg    <= errs_c;
                    stride_reg  <= errs_c + SW'(2);
                    div_dvd_reg <= DVW'(W);
                    div_dsr_reg <= DVW'(errs_c) + DVW'(2);
                    div_rem_reg <= '0;
                    div_q_reg   <= '0;
                    div_cnt_reg <= '0;
                    state_reg   <= ST_DIVA;
                end
                ST_DIVA:
                begin
                    if (div_cnt_reg == DCW'(DVW - 1))
                    begin
                        // diagonals per word
                        pw_reg      <= SW'(div_q_new);
                        div_dsr_reg <= div_q_new;
                        div_dvd_reg <= span - DVW'(1);
                        div_rem_reg <= '0;
                        div_q_reg   <= '0;
                        div_cnt_reg <= '0;
                        state_reg   <= ST_DIVB;
                    end
                    else
                    begin
                        div_rem_reg <= div_rem_new;
                        div_q_reg   <= div_q_new;
                        div_dvd_reg <= div_dvd_reg << 1;
                        div_cnt_reg <= div_cnt_reg + DCW'(1);
                    end
                end
                ST_DIVB:
                begin
                    div_rem_reg <= div_rem_new;
                    div_q_reg   <= div_q_new;
                    div_dvd_reg <= div_dvd_reg << 1;
                    div_cnt_reg <= div_cnt_reg + DCW'(1);
                    if (div_cnt_reg == DCW'(DVW - 1))
                    begin
                        // saturate the last block index
                        if (div_q_new > DVW'(MAX_BLOCKS - 1))
                            last_blk_reg <= AW'(MAX_BLOCKS - 1);
                        else
                            last_blk_reg <= AW'(div_q_new);
                        shiftj_reg <= (spanmod == SW'(0)) ? SW'(0) : pw_reg - spanmod;
                        din_reg    <= m3;
                        m1_reg     <= ONE_W;
                        mi_reg     <= SW'(1);
                        state_reg  <= ST_MASK;
                    end
                end
                ST_MASK:
                begin
                    if (mi_reg < pw_reg)
                    begin
                        din_reg <= din_reg | (din_reg << stride_reg);
                        m1_reg  <= m1_reg | (m1_reg << stride_reg);
                        mi_reg  <= mi_reg + SW'(1);
                    end
                    else
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    m2_reg         <= m1_reg | m3;
                    gl_reg         <= ONE_W << gl_amt;
                    gi_reg         <= ONE_W << errs_reg;
                    ld_reg         <= SW'(ld_full);
                    fw_reg         <= din_reg;
                    diag_valid_reg <= '0;
                    a_reg          <= '0;
                    pos_reg        <= '0;
                    state_reg      <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (cfg_acc)
                    begin
                        case (cfg_index)
                            REG_MAX_ERRORS:     max_errors_reg     <= cfg_data[KERR_W-1:0];
                            REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[PLEN_W-1:0];
                            default:            max_errors_reg     <= max_errors_reg;
                        endcase
                        state_reg <= ST_INIT;
                    end
                    else if (in_acc)
                    begin
                        case (in_cmd)
                            CMD_TEXT:
                            begin
                                pos_reg     <= pos_reg + POS_W'(1);
                                sym_reg     <= in_sym;
                                sym_oor_reg <= !in_sym_ok;
                                cnt_reg     <= '0;
                                cprev_reg   <= '0;
                                state_reg   <= (a_reg == AW'(0)) ? ST_FILT : ST_RUN;
                            end
                            CMD_RESTART:
                            begin
                                // restore the search state, keep the table
                                fw_reg         <= din_reg;
                                diag_valid_reg <= '0;
                                a_reg          <= '0;
                                pos_reg        <= '0;
                            end
                            default:
                            begin
                                // loads go straight to the table; unused code drops
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_FILT:
                begin
                    if (last_blk_reg == AW'(0))
                    begin
                        if ((fc & gl_reg) == '0)
                        begin
                            if (out_free)
                            begin
                                out_valid_reg <= 1'b1;
                                out_data_reg  <= pos_reg;
                                fw_reg        <= fc;
                                state_reg     <= ST_IDLE;
                            end
                        end
                        else
                        begin
                            fw_reg    <= fc;
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        fw_reg <= fc;
                        if ((fc & gi_reg) == '0)
                            a_reg <= AW'(1);
                        state_reg <= ST_IDLE;
                    end
                end
                ST_RUN:
                begin
                    old_reg <= diag_eff;
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg >= CW'(2))
                    begin
                        prev_new_reg <= rnew;
                        cprev_reg    <= old_reg;
                        if (j_idx == a_reg)
                        begin
                            top_reg   <= rnew;
                            below_reg <= prev_new_reg;
                            state_reg <= ST_POST;
                        end
                    end
                end
                ST_POST:
                begin
                    if ((top_reg & g_sel) != '0)
                    begin
                        state_reg <= ST_SHRINK;
                    end
                    else if (a_reg == last_blk_reg)
                    begin
                        if (out_free)
                        begin
                            out_valid_reg <= 1'b1;
                            out_data_reg  <= pos_reg;
                            state_reg     <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        a_reg     <= a_reg + AW'(1);
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SHRINK:
                begin
                    if (shrink_ok)
                    begin
                        a_reg <= a_dec;
                        if (a_dec == AW'(0))
                        begin
                            // back to the filter word alone
                            fw_reg    <= below_reg;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            top_reg   <= below_reg;
                            state_reg <= ST_SHRD;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SHRD:
                begin
                    below_reg <= diag_eff;
                    state_reg <= ST_SHRINK;
                end
                default:
                begin
                    state_reg <= ST_INIT;
                end
            endcase
        end
    end

    // ---------------- assertions ----------------
    a_active_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (a_reg <= last_blk_reg))
        else $error("active block count beyond last block");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == ST_FILT || $past(state_reg) == ST_POST))
        else $error("result raised outside a match decision");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && diag_we) |-> (diag_waddr != diag_raddr))
        else $error("diagonal memory read and write collide");

    a_shrink_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHRINK || state_reg == ST_POST) |-> (a_reg != AW'(0)))
        else $error("block update with no active block");

endmodule

`default_nettype wire

// ===== tb/approximate_text_matcher_tb.sv =====
`timescale 1ns / 1ps

module approximate_text_matcher_tb;
    import atm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 110;
    localparam int SETTLE_CYCLES  = 120;

    typedef struct packed {
        logic [TWORD_W-1:0] table_word;
        logic [BLK_W-1:0]   block_index;
        logic [SYM_W-1:0]   symbol;
        logic [CMD_W-1:0]   command;
    } scan_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [POS_W-1:0]      m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    approximate_text_matcher i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Matcher prediction: own copy of the table, diagonal words and masks
    // ------------------------------------------------------------------
    logic [63:0] match_table [0:2047];
    logic [63:0] diag_word [0:16];
    logic [63:0] filter_q;
    int          active_cnt;
    logic [31:0] text_pos;
    logic [63:0] msk_m1, msk_m2, msk_m3, msk_din, msk_gl, msk_gi;
    int          errs, per_word, last_blk;
    int          cfg_k = 0;
    int          cfg_m = 1;

    logic [POS_W-1:0] end_positions_due [$];
    int               mismatches = 0;

    function automatic logic [63:0] shl64(input logic [63:0] v, input int s);
        return (s >= 64) ? 64'd0 : (v << s);
    endfunction

    function automatic logic [63:0] shr64(input logic [63:0] v, input int s);
        return (s >= 64) ? 64'd0 : (v >> s);
    endfunction

    task automatic restart_search();
        for (int j = 0; j <= 16; j++)
            diag_word[j] = msk_din;
        filter_q   = msk_din;
        active_cnt = 0;
        text_pos   = '0;
    endtask

    task automatic derive_masks();
        int stride;
        int span;
        int shift_j;
        errs = (cfg_k > 62) ? 62 : cfg_k;
        stride = errs + 2;
        per_word = 64 / stride;
        span = (cfg_m > errs) ? cfg_m - errs : 1;
        last_blk = (span - 1) / per_word;
        if (last_blk > 15)
            last_blk = 15;
        msk_m3 = shl64(64'd1, errs + 1) - 64'd1;
        msk_din = msk_m3;
        msk_m1 = 64'd1;
        for (int i = 1; i < per_word; i++)
        begin
            msk_din |= shl64(msk_din, stride);
            msk_m1  |= shl64(msk_m1, stride);
        end
        shift_j = (per_word - span % per_word) % per_word;
        msk_m2 = msk_m1 | msk_m3;
        msk_gl = shl64(64'd1, stride * shift_j + errs);
        msk_gi = shl64(64'd1, errs);
        restart_search();
    endtask

    function automatic logic [63:0] table_fetch(input logic [6:0] sym, input int blk);
        return match_table[{sym, blk[3:0]}];
    endfunction

    // advance the automaton by one transaction; push an end position on a match
    task automatic advance_matcher(input scan_item_t it);
        logic [63:0] x;
        logic [63:0] c;
        logic [63:0] old;
        logic [63:0] g;
        int          stride;
        int          ld;
        bit          shrinking;
        stride = errs + 2;
        ld = stride * (per_word - 1);
        case (it.command)
            CMD_LOAD:
                match_table[{it.symbol, it.block_index}] = it.table_word;
            CMD_RESTART:
                restart_search();
            CMD_TEXT:
            begin
                text_pos++;
                if (active_cnt == 0)
                begin
                    c = filter_q;
                    if (per_word == 1)
                    begin
                        x = table_fetch(it.symbol, 0);
                        c = (shl64(c, 1) | 64'd1) & shr64((x + 64'd1) ^ x, 1) & msk_din;
                    end
                    else
                    begin
                        x = shr64(c, stride) | table_fetch(it.symbol, 0);
                        c = (shl64(c, 1) | msk_m1) & (shl64(c, stride + 1) | msk_m2)
                          & shr64((x + msk_m1) ^ x, 1) & msk_din;
                    end
                    filter_q = c;
                    if (last_blk == 0)
                    begin
                        if ((c & msk_gl) == 0)
                            end_positions_due.push_back(text_pos);
                        return;
                    end
                    if ((c & msk_gi) == 0)
                    begin
                        active_cnt = 1;
                        diag_word[0] = c;
                    end
                    return;
                end
                c = '0;
                for (int j = 0; j <= active_cnt; j++)
                begin
                    old = diag_word[j];
                    if (per_word == 1)
                    begin
                        x = c | table_fetch(it.symbol, j);
                        diag_word[j] = (shl64(old & diag_word[j + 1], 1) | 64'd1)
                                     & shr64((x + 64'd1) ^ x, 1) & msk_din;
                    end
                    else
                    begin
                        x = shr64(old, stride) | shl64(c, ld) | table_fetch(it.symbol, j);
                        diag_word[j] = ((shl64(old, 1) & (shl64(old, stride + 1)
                                       | shr64(diag_word[j + 1], ld - 1))) | msk_m1)
                                     & shr64((x + msk_m1) ^ x, 1) & msk_din;
                    end
                    c = old;
                end
                g = (active_cnt == last_blk) ? msk_gl : msk_gi;
                if ((diag_word[active_cnt] & g) != 0)
                begin
                    // drop trailing blocks that have gone fully inactive
                    shrinking = 1'b1;
                    while (shrinking && ((~diag_word[active_cnt] & msk_din) == 0))
                    begin
                        if ((diag_word[active_cnt - 1] & msk_gi) != 0)
                        begin
                            active_cnt--;
                            if (active_cnt == 0)
                                shrinking = 1'b0;
                        end
                        else
                            shrinking = 1'b0;
                    end
                end
                else if (active_cnt == last_blk)
                begin
                    end_positions_due.push_back(text_pos);
                    return;
                end
                else
                    active_cnt++;
                if (active_cnt == 0)
                    filter_q = diag_word[0];
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: feeds transactions from the pending queue in bursts
    // ------------------------------------------------------------------
    scan_item_t pending_items [$];
    int         issued_cnt = 0;
    int         accepted_cnt = 0;
    logic       s_taken = 1'b0;
    int         burst_left = 8;
    int         gap_left = 0;

    always @(negedge clk)
    begin
        if (rst_n && !(s_axis_tvalid && !s_taken))
        begin
            if (gap_left > 0)
            begin
                s_axis_tvalid <= 1'b0;
                gap_left--;
            end
            else if (pending_items.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= IN_TDATA_W'(pending_items.pop_front());
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver: stall pattern switches between always ready, random and periodic
    int stall_mode = 0;
    int rx_cycle = 0;

    always @(negedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 400 == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 9) < 6);
            default: m_axis_tready <= ((rx_cycle % 11) > 3);
        endcase
    end

    // ------------------------------------------------------------------
    // Monitor: check results, then predict from accepted transactions
    // ------------------------------------------------------------------
    int         idle_cycles = 0;
    logic [POS_W-1:0] due_pos;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            s_taken <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (end_positions_due.size() == 0)
                begin
                    $display("%0t: unexpected end position, expected none, actual %0d",
                             $time, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    due_pos = end_positions_due.pop_front();
                    if (m_axis_tdata !== due_pos)
                    begin
                        $display("%0t: end_position mismatch, expected %0d, actual %0d",
                                 $time, due_pos, m_axis_tdata);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MAX_ERRORS)
                    cfg_k = cfg_data[KERR_W-1:0];
                else
                    cfg_m = cfg_data;
                derive_masks();
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                advance_matcher(scan_item_t'(s_axis_tdata[IN_W-1:0]));
                accepted_cnt++;
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    int  blocks_written [0:127];
    bit  entry_written [0:2047];
    int  usable_syms [$];

    function automatic logic [63:0] random_word(input int density);
        logic [63:0] w;
        w = {$urandom, $urandom};
        case (density)
            0:       w = '0;
            1:       w = '1;
            2:       w = w & {$urandom, $urandom};
            3:       w = w & {$urandom, $urandom} & {$urandom, $urandom}
                       & {$urandom, $urandom};
            default: ;
        endcase
        return w;
    endfunction

    task automatic queue_item(input cmd_t cmd, input int sym, input int blk,
                              input logic [63:0] word);
        scan_item_t it;
        it.command     = cmd;
        it.symbol      = sym[6:0];
        it.block_index = blk[3:0];
        it.table_word  = word;
        if (cmd == CMD_LOAD && !entry_written[{it.symbol, it.block_index}])
        begin
            entry_written[{it.symbol, it.block_index}] = 1'b1;
            blocks_written[sym]++;
            if (blocks_written[sym] == 16)
                usable_syms.push_back(sym);
        end
        pending_items.push_back(it);
        issued_cnt++;
    endtask

    task automatic queue_raw(input logic [1:0] cmd);
        scan_item_t it;
        it = {{$urandom, $urandom}, 4'($urandom), 7'($urandom), cmd};
        pending_items.push_back(it);
        issued_cnt++;
    endtask

    task automatic wait_idle();
        while (accepted_cnt != issued_cnt || end_positions_due.size() != 0)
            @(negedge clk);
        // a non-matching symbol may still be sweeping its blocks
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    int preload_syms [8] = '{0, 127, 1, 2, 85, 42, 64, 3};
    int preload_dens [8] = '{0, 1, 3, 2, 3, 4, 3, 2};
    int phase_k [PHASES] = '{0, 63, 62, 1, 3, 7, 31, 5, 20, 2};
    int phase_m [PHASES] = '{2047, 1, 1024, 40, 0, 12, 100, 5, 300, 64};
    int pick;

    initial
    begin
        for (int s = 0; s < 128; s++)
            blocks_written[s] = 0;
        for (int e = 0; e < 2048; e++)
            entry_written[e] = 1'b0;
        cfg_k = 0;
        cfg_m = 1;
        derive_masks();

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // fill every block of a handful of symbols before any text reads them
        for (int s = 0; s < 8; s++)
            for (int b = 0; b < 16; b++)
                queue_item(CMD_LOAD, preload_syms[s], b, random_word(preload_dens[s]));

        // directed: extremes, every command, unused command, restart mid-text
        queue_item(CMD_TEXT, 0, 0, '0);
        queue_item(CMD_TEXT, 127, 15, '1);
        queue_item(CMD_TEXT, 0, 0, '0);
        queue_item(CMD_RESTART, 127, 15, '1);
        queue_item(CMD_TEXT, 0, 0, '0);
        queue_raw(2'd3);
        queue_item(CMD_LOAD, 127, 15, '1);
        queue_item(CMD_LOAD, 0, 15, 64'h8000_0000_0000_0001);
        queue_item(CMD_TEXT, 127, 0, '0);
        queue_item(CMD_TEXT, 1, 0, '0);
        queue_item(CMD_TEXT, 0, 0, '0);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            write_reg(REG_MAX_ERRORS, phase_k[p]);
            write_reg(REG_PATTERN_LENGTH, phase_m[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    queue_item(CMD_LOAD, $urandom_range(0, 127), $urandom_range(0, 15),
                               random_word($urandom_range(0, 4)));
                else if (pick < 12)
                    queue_item(CMD_RESTART, $urandom_range(0, 127), 0, '0);
                else if (pick < 14)
                    queue_raw(2'd3);
                else if (pick < 60)
                    // long runs of the all-match symbol drive blocks deep
                    queue_item(CMD_TEXT, 0, $urandom_range(0, 15), {$urandom, $urandom});
                else
                    queue_item(CMD_TEXT,
                               usable_syms[$urandom_range(0, usable_syms.size() - 1)],
                               $urandom_range(0, 15), {$urandom, $urandom});
            end
        end

        while (accepted_cnt != issued_cnt || end_positions_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (mismatches == 0 && end_positions_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
